### rtl/core/mexp_pkg.sv
// Package for the modular exponentiation block: shared constants, the controller
// state type and the command and status bundles between controller and datapath.
// No dependencies.
package mexp_pkg;

    // Default data width and the modulus held after reset.
    localparam int          WORD_BITS_DEFAULT = 64;
    localparam logic [63:0] MODULUS_RESET     = 64'd1000000007;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_WB_BASE,
        ST_TEST,
        ST_MUL_ACC,
        ST_WB_ACC,
        ST_MUL_SQ,
        ST_WB_SQ,
        ST_DONE
    } t_state;

    // Operand selection for a new run of the shared modular multiplier.
    typedef enum logic [1:0] {
        MSRC_REDUCE,
        MSRC_ACC,
        MSRC_SQUARE
    } t_mul_src;

    // Destination of a finished multiplier result.
    typedef enum logic [1:0] {
        WB_NONE,
        WB_BASE,
        WB_ACC
    } t_wb_dst;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     mul_load;
        t_mul_src mul_src;
        logic     mul_step;
        t_wb_dst  wb_dst;
        logic     exp_shift;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_last;
        logic exp_bit;
        logic exp_last;
    } t_status;

endpackage

### rtl/core/mexp_datapath.sv
// Datapath of the modular exponentiation block: modulus register, operand
// registers and the bit-serial interleaved modular multiplier.
// Depends on mexp_pkg.
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WORD_BITS-1:0] i_cfg_modulus,
    input  logic [WORD_BITS-1:0] i_base_value,
    input  logic [WORD_BITS-1:0] i_exponent,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic [WORD_BITS-1:0] o_result
);

    localparam int CNT_BITS = $clog2(WORD_BITS);
    localparam logic [WORD_BITS-1:0] MOD_RST_RAW = MODULUS_RESET[WORD_BITS-1:0];
    localparam logic [WORD_BITS-1:0] MOD_RST =
        (MOD_RST_RAW == '0) ? WORD_BITS'(1) : MOD_RST_RAW;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] r_modulus;
    logic [WORD_BITS-1:0] r_base;
    logic [WORD_BITS-1:0] r_exp;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_prod;
    logic [WORD_BITS-1:0] r_mcand;
    logic [WORD_BITS-1:0] r_mplier;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [CNT_BITS-1:0]  r_ecnt;

    logic [WORD_BITS-1:0] n_prod;
    logic [WORD_BITS+1:0] w_sum;
    logic [WORD_BITS+1:0] w_m1;
    logic [WORD_BITS+1:0] w_m2;
    logic [WORD_BITS+1:0] w_red;

    // The modulus is only replaced by a nonzero value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RST;
        end else if (i_cfg_we && (i_cfg_modulus != '0)) begin
            r_modulus <= i_cfg_modulus;
        end
    end

    // One multiplier step: double the partial product, add the multiplicand when
    // the current multiplier bit is set, then bring the sum back below the
    // modulus. The sum stays below three times the modulus.
    always_comb begin
        w_m1  = {2'b00, r_modulus};
        w_m2  = {1'b0, r_modulus, 1'b0};
        w_sum = {1'b0, r_prod, 1'b0}
              + (r_mplier[WORD_BITS-1] ? {2'b00, r_mcand} : '0);
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        n_prod = w_red[WORD_BITS-1:0];
    end

    // Multiplier registers. The base is reduced by running the same loop with a
    // multiplicand of one over the bits of the raw base.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod   <= '0;
            r_mcand  <= WORD_BITS'(1);
            r_mplier <= i_base_value;
            r_cnt    <= '0;
        end else if (i_cmd.mul_load) begin
            r_prod <= '0;
            r_cnt  <= '0;
            case (i_cmd.mul_src)
                MSRC_ACC: begin
                    r_mcand  <= r_base;
                    r_mplier <= r_acc;
                end
                MSRC_SQUARE: begin
                    r_mcand  <= r_base;
                    r_mplier <= r_base;
                end
                default: begin
                    r_mcand  <= WORD_BITS'(1);
                    r_mplier <= r_base;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            r_prod   <= n_prod;
            r_mplier <= {r_mplier[WORD_BITS-2:0], 1'b0};
            r_cnt    <= r_cnt + CNT_BITS'(1);
        end
    end

    // Operand registers: exponent shifts right one bit per square.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exp  <= i_exponent;
            r_ecnt <= '0;
            r_acc  <= (r_modulus == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
        end else begin
            case (i_cmd.wb_dst)
                WB_BASE: r_base <= r_prod;
                WB_ACC:  r_acc  <= r_prod;
                default: ;
            endcase
            if (i_cmd.exp_shift) begin
                r_exp  <= {1'b0, r_exp[WORD_BITS-1:1]};
                r_ecnt <= r_ecnt + CNT_BITS'(1);
            end
        end
    end

    // Status back to the controller.
    always_comb begin
        o_status.mul_last = (r_cnt == CNT_LAST);
        o_status.exp_bit  = r_exp[0];
        o_status.exp_last = (r_ecnt == CNT_LAST);
    end

    assign o_result = r_acc;

endmodule

### rtl/core/mexp_ctrl.sv
// Controller of the modular exponentiation block: sequences base reduction and
// the square-and-multiply loop over the exponent bits. Depends on mexp_pkg.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_start) n_state = ST_REDUCE;
            ST_REDUCE:  if (i_status.mul_last) n_state = ST_WB_BASE;
            ST_WB_BASE: n_state = ST_TEST;
            ST_TEST:    n_state = i_status.exp_bit ? ST_MUL_ACC : ST_MUL_SQ;
            ST_MUL_ACC: if (i_status.mul_last) n_state = ST_WB_ACC;
            ST_WB_ACC:  n_state = ST_MUL_SQ;
            ST_MUL_SQ:  if (i_status.mul_last) n_state = ST_WB_SQ;
            ST_WB_SQ:   n_state = i_status.exp_last ? ST_DONE : ST_TEST;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        o_cmd.load      = 1'b0;
        o_cmd.mul_load  = 1'b0;
        o_cmd.mul_src   = MSRC_REDUCE;
        o_cmd.mul_step  = 1'b0;
        o_cmd.wb_dst    = WB_NONE;
        o_cmd.exp_shift = 1'b0;
        o_busy          = 1'b1;
        o_valid         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_REDUCE, ST_MUL_ACC, ST_MUL_SQ: begin
                o_cmd.mul_step = 1'b1;
            end
            ST_WB_BASE: begin
                o_cmd.wb_dst = WB_BASE;
            end
            ST_TEST: begin
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_src  = i_status.exp_bit ? MSRC_ACC : MSRC_SQUARE;
            end
            ST_WB_ACC: begin
                o_cmd.wb_dst   = WB_ACC;
                o_cmd.mul_load = 1'b1;
                o_cmd.mul_src  = MSRC_SQUARE;
            end
            ST_WB_SQ: begin
                o_cmd.wb_dst    = WB_BASE;
                o_cmd.exp_shift = 1'b1;
            end
            ST_DONE: begin
                o_valid = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/modular_exponentiation.sv
// Top level of the modular exponentiation block: base^exponent mod modulus by
// right-to-left square-and-multiply. Depends on mexp_pkg, mexp_ctrl, mexp_datapath.
//
// Usage: the modulus register is written through i_cfg_we / i_cfg_modulus while
// the block is idle; a write of zero is ignored. After reset it holds 1000000007.
// A beat on the input side is accepted when start is high and busy is low;
// base and exponent are sampled at that edge. busy stays high until the result
// beat has been shown. The result appears on o_power_residue for exactly one
// cycle with o_valid high; the receiver cannot stall it.
// One item is worked on at a time and a new one may be accepted in the cycle after
// the result. The time is set by the single shared bit-serial modular multiplier:
// one multiplier bit per cycle, up to two products per exponent bit, plus one
// product to reduce the base.
// Reset is synchronous and returns the controller to idle; no result is lost
// since none is in flight when a result strobe has been given.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WORD_BITS-1:0] i_cfg_modulus,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_base_value,
    input  logic [WORD_BITS-1:0] i_exponent,
    output logic                 o_valid,
    output logic [WORD_BITS-1:0] o_power_residue
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencing of the reduction and the exponent loop.
    mexp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // Registers and the modular multiplier.
    mexp_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_modulus (i_cfg_modulus),
        .i_base_value  (i_base_value),
        .i_exponent    (i_exponent),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_result      (o_power_residue)
    );

endmodule
